// ===== sv/esw_pkg.sv =====
// shared types and codes for the edge span walker
// used by esw_divider, edge_span_walker and the bench; no dependencies

package esw_pkg;

	// item beat codes
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_STEP = 1'b1;

	// status of the iterative divider as seen by its sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} esw_div_stat_t;

endpackage

// ===== sv/esw_item_if.sv =====
// input channel of the edge span walker: load or step beats
// valid/ready handshake, payload widths follow COORD_BITS

interface esw_item_if #(
	parameter int COORD_BITS = 16
) ();
	logic                         valid;
	logic                         ready;
	logic                         mode;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;

	modport source (
		output valid, mode, start_x, start_y, end_x, end_y,
		input  ready
	);

	modport sink (
		input  valid, mode, start_x, start_y, end_x, end_y,
		output ready
	);
endinterface

// ===== sv/esw_span_if.sv =====
// output channel of the edge span walker: one span beat per item
// valid/ready handshake, payload widths follow COORD_BITS

interface esw_span_if #(
	parameter int COORD_BITS = 16
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS:0]   span_begin;
	logic signed [COORD_BITS:0]   span_end;
	logic signed [COORD_BITS-1:0] span_row;
	logic                         at_bottom;
	logic                         span_valid;

	modport source (
		output valid, span_begin, span_end, span_row, at_bottom, span_valid,
		input  ready
	);

	modport sink (
		input  valid, span_begin, span_end, span_row, at_bottom, span_valid,
		output ready
	);
endinterface

// ===== sv/esw_divider.sv =====
// restoring unsigned divider, one quotient bit per cycle
// depends on esw_pkg for the status struct

module esw_divider
	import esw_pkg::*;
#(
	parameter int NW = 18,
	parameter int DW = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output esw_div_stat_t stat,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem
);
	localparam int CW = $clog2(NW + 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;

	logic [DW:0]   shifted;
	logic [DW:0]   diff;
	logic          ge;

	assign shifted = {rem_q, quo_q[NW-1]};
	assign ge      = shifted >= {1'b0, den_q};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CW'(NW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			// remainder stays below den, so the low DW bits hold it
			rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = quo_q;
	assign rem       = rem_q;
endmodule

// ===== sv/edge_span_walker.sv =====
// edge span walker: one span beat per load or step beat.
// x-major load: LOAD1, LOAD2, LOAD3, DIVSET, DIVWAIT, FIN, EMIT; x-major step: DIVSET, DIVWAIT, FIN,
// EMIT, with DIVWAIT held by the bit-serial divider (COORD_BITS+2 quotient bits, one per cycle).
// y-major or horizontal load: LOAD1-3, EMIT; y-major step: STEP, YM2, EMIT; past the bottom row: EMIT.
// one item at a time: next beat taken the cycle after the span is registered.
// arst_n clears the sequencer, the output valid, the divider and live_q; no edge is loaded.

module edge_span_walker
	import esw_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	esw_item_if.sink    items,
	esw_span_if.source  spans
);
	localparam int N  = COORD_BITS;
	localparam int XW = N + 1;   // span x, wraps like the output field
	localparam int AW = N + 2;   // doubled |dx|, dividend
	localparam int DW = N + 1;   // doubled dy, divisor
	localparam int EW = N + 3;   // error accumulator

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_LOAD1   = 4'd1;
	localparam logic [3:0] S_LOAD2   = 4'd2;
	localparam logic [3:0] S_LOAD3   = 4'd3;
	localparam logic [3:0] S_STEP    = 4'd4;
	localparam logic [3:0] S_YM2     = 4'd5;
	localparam logic [3:0] S_DIVSET  = 4'd6;
	localparam logic [3:0] S_DIVWAIT = 4'd7;
	localparam logic [3:0] S_FIN     = 4'd8;
	localparam logic [3:0] S_EMIT    = 4'd9;

	localparam logic [XW-1:0] X_ONE = XW'(1);

	logic [3:0] state_q;

	logic signed [N-1:0]  xt_q, yt_q, xb_q, yb_q;
	logic signed [XW-1:0] dx_q;
	logic [N-1:0]         dy_q;
	logic [AW-1:0]        adx2_q;
	logic [DW-1:0]        dy2_q;
	logic [EW-1:0]        e_q;
	logic signed [XW-1:0] left_q, right_q;
	logic signed [N-1:0]  bot_q, cur_q;
	logic                 live_q;
	logic                 xmaj_q;
	logic                 dneg_q, dpos_q;
	logic                 load_q;
	logic                 ok_q;

	logic                 out_v_q;
	logic signed [XW-1:0] out_begin_q, out_end_q;
	logic signed [N-1:0]  out_row_q;
	logic                 out_bot_q, out_ok_q;

	logic                 accept;
	logic                 swap;
	logic [XW-1:0]        adx;
	logic                 xmaj_c;
	logic [XW-1:0]        xt_x, xb_x;
	logic [XW-1:0]        qx;
	logic                 emit_go;

	logic                 div_start;
	logic [AW-1:0]        div_num;
	esw_div_stat_t        div_stat;
	logic [AW-1:0]        div_quo;
	logic [DW-1:0]        div_rem;

	assign accept  = items.valid && items.ready;
	assign swap    = items.end_y < items.start_y;
	assign adx     = dx_q[XW-1] ? XW'(-dx_q) : XW'(dx_q);
	assign xmaj_c  = adx2_q > AW'(dy2_q);
	assign xt_x    = {xt_q[N-1], xt_q};
	assign xb_x    = {xb_q[N-1], xb_q};
	assign qx      = div_quo[XW-1:0];
	assign emit_go = !out_v_q || spans.ready;

	assign div_start = state_q == S_DIVSET;
	assign div_num   = AW'(EW'(adx2_q) - e_q);

	esw_divider #(
		.NW(AW),
		.DW(DW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (dy2_q),
		.stat  (div_stat),
		.quo   (div_quo),
		.rem   (div_rem)
	);

	// sequencer and control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			live_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (out_v_q && spans.ready && state_q != S_EMIT) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (items.mode == MODE_LOAD) begin
							state_q <= S_LOAD1;
						end else if (live_q && cur_q < bot_q) begin
							state_q <= xmaj_q ? S_DIVSET : S_STEP;
						end else begin
							live_q  <= 1'b0;
							state_q <= S_EMIT;
						end
					end
				end
				S_LOAD1: begin
					live_q  <= 1'b1;
					state_q <= S_LOAD2;
				end
				S_LOAD2:   state_q <= S_LOAD3;
				S_LOAD3:   state_q <= (xmaj_c && dy_q != '0) ? S_DIVSET : S_EMIT;
				S_STEP:    state_q <= S_YM2;
				S_YM2:     state_q <= S_EMIT;
				S_DIVSET:  state_q <= S_DIVWAIT;
				S_DIVWAIT: begin
					if (div_stat.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN:     state_q <= S_EMIT;
				S_EMIT: begin
					if (emit_go) begin
						out_v_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	// edge datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (items.mode == MODE_LOAD) begin
						// order endpoints top to bottom
						xt_q <= swap ? items.end_x : items.start_x;
						yt_q <= swap ? items.end_y : items.start_y;
						xb_q <= swap ? items.start_x : items.end_x;
						yb_q <= swap ? items.start_y : items.end_y;
					end else if (live_q && cur_q < bot_q) begin
						cur_q  <= cur_q + N'(1);
						load_q <= 1'b0;
						ok_q   <= 1'b1;
					end else begin
						ok_q <= 1'b0;
					end
				end
			end
			S_LOAD1: begin
				dx_q   <= xb_x - xt_x;
				dy_q   <= yb_q - yt_q;
				bot_q  <= yb_q;
				cur_q  <= yt_q;
				load_q <= 1'b1;
				ok_q   <= 1'b1;
			end
			S_LOAD2: begin
				adx2_q <= {adx, 1'b0};
				dy2_q  <= {dy_q, 1'b0};
				dneg_q <= dx_q[XW-1];
				dpos_q <= !dx_q[XW-1] && dx_q != '0;
			end
			S_LOAD3: begin
				xmaj_q <= xmaj_c;
				if (xmaj_c) begin
					if (dy_q != '0) begin
						e_q <= EW'(adx2_q[AW-1:1]) - EW'(dneg_q);
					end else begin
						// horizontal edge: inclusive span lesser x to greater x
						e_q     <= EW'(adx2_q[AW-1:1]);
						left_q  <= (xt_q < xb_q) ? xt_x : xb_x;
						right_q <= (xt_q < xb_q) ? xb_x : xt_x;
					end
				end else begin
					e_q     <= EW'(dy_q);
					left_q  <= xt_x;
					right_q <= xt_x + X_ONE;
				end
			end
			S_STEP: begin
				e_q <= e_q + EW'(adx2_q);
			end
			S_YM2: begin
				if (e_q > EW'(dy2_q)) begin
					e_q <= e_q - EW'(dy2_q);
					if (dpos_q) begin
						left_q  <= left_q + X_ONE;
						right_q <= right_q + X_ONE;
					end else begin
						left_q  <= left_q - X_ONE;
						right_q <= right_q - X_ONE;
					end
				end
			end
			S_FIN: begin
				// run is quotient + 1, new error is dy2 - remainder
				e_q <= EW'(dy2_q) - EW'(div_rem);
				if (load_q) begin
					if (dpos_q) begin
						left_q  <= xt_x;
						right_q <= xt_x + qx + X_ONE;
					end else begin
						right_q <= xt_x + X_ONE;
						left_q  <= xt_x - qx;
					end
				end else if (dpos_q) begin
					left_q  <= right_q;
					right_q <= right_q + qx + X_ONE;
				end else begin
					// left - (q + 1) is left + ~q
					right_q <= left_q;
					left_q  <= left_q + ~qx;
				end
			end
			S_EMIT: begin
				if (emit_go) begin
					out_begin_q <= ok_q ? left_q : '0;
					out_end_q   <= ok_q ? right_q : '0;
					out_row_q   <= ok_q ? cur_q : '0;
					out_bot_q   <= ok_q && cur_q == bot_q;
					out_ok_q    <= ok_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign items.ready      = state_q == S_IDLE;
	assign spans.valid      = out_v_q;
	assign spans.span_begin = out_begin_q;
	assign spans.span_end   = out_end_q;
	assign spans.span_row   = out_row_q;
	assign spans.at_bottom  = out_bot_q;
	assign spans.span_valid = out_ok_q;
endmodule
